/* hw/rtl/picf_pkg.sv */
`default_nettype none

package picf_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W = 16;
  localparam int RW      = 15;

  // Coordinates are taken as COORD_BITS-bit two's complement values
  localparam int COORD_BITS = 16;
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;               // difference of two coordinates
  localparam int LW  = 2 * DW;               // square or sum of three squares
  localparam int NW  = LW + 1;               // signed dot product
  localparam int TW  = RW + LW;              // radius times axis length
  localparam int CNW = TW + 1;               // cone radius times L
  localparam int CH  = (CNW + 1) / 2;        // low half of cone for squaring
  localparam int CU  = CNW - CH;             // high half of cone
  localparam int LHW = 3 * LW;
  localparam int RHW = 2 * CNW;
  localparam int CMPW = (LHW > RHW) ? LHW : RHW;

  localparam int NSTG = 9;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_END_A_X    = 3'd0;
  localparam logic [2:0] REG_END_A_Y    = 3'd1;
  localparam logic [2:0] REG_END_A_Z    = 3'd2;
  localparam logic [2:0] REG_END_B_X    = 3'd3;
  localparam logic [2:0] REG_END_B_Y    = 3'd4;
  localparam logic [2:0] REG_END_B_Z    = 3'd5;
  localparam logic [2:0] REG_RADIUS_A   = 3'd6;
  localparam logic [2:0] REG_RADIUS_B   = 3'd7;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } out_item_t;

  // Cone geometry as seen by the datapath
  typedef struct packed {
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] az;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic [LW-1:0]        len;
    logic [RW-1:0]        ra;
    logic [RW-1:0]        rb;
  } axis_t;

  function automatic logic signed [DW-1:0] sext_coord(input logic [FIELD_W-1:0] v);
    logic [CW-1:0] t;
    t = CW'(v);
    return $signed({t[CW-1], t});
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/point_in_cone_frustum.sv */
// Truncated cone membership test, one query point per transaction.
// Nine register stages, the first loaded at acceptance (widest step: the squared
// cone radius, in halves).
// Throughput: one transaction per cycle; stalls back up stage by stage.
// Reset (rst_n low, synchronous): config registers and valid flags clear to 0, pipeline empties.
// An end-point write reaches the datapath through the axis register, then the length register.
`default_nettype none

module point_in_cone_frustum
  import picf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // query points
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // test results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // register port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  // Cone geometry: end A, axis D = B - A, L = |D|^2 and the two radii.
  // The user must hold it stable while transactions are in flight; the block does not enforce it.
  axis_t axis;

  picf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .axis        (axis)
  );

  // Exact integer test, multiplied through by L:
  //   stage 0      U = P - A
  //   stages 1..2  n = U.D, S = |U|^2, range check 0 <= n <= L
  //   stages 3..5  perp = S*L - n^2, cone = rA*(L-n) + rB*n
  //   stages 5..7  lhs = perp*L, rhs = cone^2 (each in partial products)
  //   stage 8      compare, drive the result register
  // Each stage holds only when it is full and the next one is not advancing, so bubbles
  // are squeezed out even while the output waits.
  picf_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (axis),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/picf_regs.sv */
`default_nettype none

module picf_regs
  import picf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output axis_t                  axis
);

  logic [FIELD_W-1:0] end_a_x_r, end_a_y_r, end_a_z_r;
  logic [FIELD_W-1:0] end_b_x_r, end_b_y_r, end_b_z_r;
  logic [RW-1:0]      radius_a_r, radius_b_r;

  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [LW-1:0]        len_r;
  logic signed [LW-1:0] sqx, sqy, sqz;
  logic [2:0]           idx;
  logic                 wr_en;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_a_x_r  <= '0;
      end_a_y_r  <= '0;
      end_a_z_r  <= '0;
      end_b_x_r  <= '0;
      end_b_y_r  <= '0;
      end_b_z_r  <= '0;
      radius_a_r <= '0;
      radius_b_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_END_A_X:  end_a_x_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_END_A_Y:  end_a_y_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_END_A_Z:  end_a_z_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_END_B_X:  end_b_x_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_END_B_Y:  end_b_y_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_END_B_Z:  end_b_z_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_RADIUS_A: radius_a_r <= cfg_pwdata[RW-1:0];
        REG_RADIUS_B: radius_b_r <= cfg_pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_END_A_X:  cfg_prdata = DATA_W'(end_a_x_r);
      REG_END_A_Y:  cfg_prdata = DATA_W'(end_a_y_r);
      REG_END_A_Z:  cfg_prdata = DATA_W'(end_a_z_r);
      REG_END_B_X:  cfg_prdata = DATA_W'(end_b_x_r);
      REG_END_B_Y:  cfg_prdata = DATA_W'(end_b_y_r);
      REG_END_B_Z:  cfg_prdata = DATA_W'(end_b_z_r);
      REG_RADIUS_A: cfg_prdata = DATA_W'(radius_a_r);
      REG_RADIUS_B: cfg_prdata = DATA_W'(radius_b_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Axis vector, then its squared length, registered from it
  always_ff @(posedge clk) begin
    dx_r <= sext_coord(end_b_x_r) - sext_coord(end_a_x_r);
    dy_r <= sext_coord(end_b_y_r) - sext_coord(end_a_y_r);
    dz_r <= sext_coord(end_b_z_r) - sext_coord(end_a_z_r);
  end

  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    len_r <= $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
  end

  always_comb begin
    axis.ax  = sext_coord(end_a_x_r);
    axis.ay  = sext_coord(end_a_y_r);
    axis.az  = sext_coord(end_a_z_r);
    axis.dx  = dx_r;
    axis.dy  = dy_r;
    axis.dz  = dz_r;
    axis.len = len_r;
    axis.ra  = radius_a_r;
    axis.rb  = radius_b_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/picf_pipe.sv */
`default_nettype none

module picf_pipe
  import picf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire axis_t     axis,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // stage 0
  logic signed [DW-1:0] ux_r, uy_r, uz_r;
  // stage 1
  logic signed [LW-1:0] pdx_r, pdy_r, pdz_r, sqx_r, sqy_r, sqz_r;
  // stage 2
  logic signed [NW-1:0] n_nxt, n_r;
  logic [LW-1:0]        s_nxt, s_r;
  logic                 ok_nxt;
  // stage 3
  logic [LW-1:0]        nu;
  logic [2*LW-1:0]      sl_r, nn_r;
  logic [LW-1:0]        ln_r, n3_r;
  // stage 4
  logic [2*LW-1:0]      perp_r;
  logic [TW-1:0]        ta_r, tb_r;
  // stage 5
  logic [CNW-1:0]       cone_r;
  logic [2*LW-1:0]      plo_r, phi_r;
  // stage 6
  logic [CMPW-1:0]      lhs6_r;
  logic [2*CU-1:0]      hh_r;
  logic [CNW-1:0]       hl_r;
  logic [2*CH-1:0]      ll_r;
  // stage 7
  logic [CMPW-1:0]      lhs7_r, rhs_r;
  // flags, stages 2 to 7
  logic [7:2]           deg_r, ok_r;
  // stage 8
  out_item_t            out_r;

  // A stage advances when it is empty or the next one advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    n_nxt  = NW'(pdx_r) + NW'(pdy_r) + NW'(pdz_r);
    s_nxt  = $unsigned(sqx_r) + $unsigned(sqy_r) + $unsigned(sqz_r);
    ok_nxt = !n_nxt[NW-1] && (n_nxt <= $signed({1'b0, axis.len}));
  end

  assign nu = n_r[LW-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux_r <= sext_coord(in_data.point_x) - axis.ax;
      uy_r <= sext_coord(in_data.point_y) - axis.ay;
      uz_r <= sext_coord(in_data.point_z) - axis.az;
    end
    if (en[1]) begin
      pdx_r <= ux_r * $signed(axis.dx);
      pdy_r <= uy_r * $signed(axis.dy);
      pdz_r <= uz_r * $signed(axis.dz);
      sqx_r <= ux_r * ux_r;
      sqy_r <= uy_r * uy_r;
      sqz_r <= uz_r * uz_r;
    end
    if (en[2]) begin
      n_r      <= n_nxt;
      s_r      <= s_nxt;
      ok_r[2]  <= ok_nxt;
      deg_r[2] <= (axis.len == '0);
    end
    if (en[3]) begin
      sl_r <= s_r * axis.len;
      nn_r <= nu * nu;
      ln_r <= axis.len - nu;
      n3_r <= nu;
    end
    if (en[4]) begin
      perp_r <= sl_r - nn_r;
      ta_r   <= axis.ra * ln_r;
      tb_r   <= axis.rb * n3_r;
    end
    if (en[5]) begin
      cone_r <= CNW'(ta_r) + CNW'(tb_r);
      plo_r  <= perp_r[LW-1:0] * axis.len;
      phi_r  <= perp_r[2*LW-1:LW] * axis.len;
    end
    if (en[6]) begin
      lhs6_r <= CMPW'(plo_r) + (CMPW'(phi_r) << LW);
      hh_r   <= cone_r[CNW-1:CH] * cone_r[CNW-1:CH];
      hl_r   <= cone_r[CNW-1:CH] * cone_r[CH-1:0];
      ll_r   <= cone_r[CH-1:0] * cone_r[CH-1:0];
    end
    if (en[7]) begin
      lhs7_r <= lhs6_r;
      rhs_r  <= (CMPW'(hh_r) << (2 * CH)) + (CMPW'(hl_r) << (CH + 1)) + CMPW'(ll_r);
    end
    for (int k = 3; k <= 7; k++) begin
      if (en[k]) begin
        ok_r[k]  <= ok_r[k-1];
        deg_r[k] <= deg_r[k-1];
      end
    end
    if (en[8]) begin
      out_r.inside_res <= ok_r[7] && !deg_r[7] && (lhs7_r <= rhs_r);
      out_r.degenerate <= deg_r[7];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/picf_sva.sv */
`default_nettype none

module picf_sva
  import picf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic [3:0] inflight_r;
  logic       acc_in, acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 4'(acc_in) - 4'(acc_out);
    end
  end

  // Degenerate axis always reports outside
  a_deg_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> !out_data.inside_res)
    else $error("degenerate result reported inside");

  // No result without an accepted transaction behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 4'd0)
    else $error("result without pending transaction");

  // Never more in flight than pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 4'(NSTG))
    else $error("too many transactions in flight");

  // An empty block takes input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 4'd0 |-> in_ready)
    else $error("empty block not ready");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind point_in_cone_frustum picf_sva u_picf_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
